>>> rtl/swre_pkg.sv
// Shared constants and width functions for the sliding-window root energy block.
`default_nettype none

package swre_pkg;

	localparam int WINDOW_MAX_DEF  = 1024;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int CFG_W           = 11;
	localparam int WINDOW_RESET    = 32;
	localparam int FRAC_BITS       = 8;

	function automatic int sum_width(int sample_bits, int window_max);
		return 2 * sample_bits - 1 + $clog2(window_max);
	endfunction

	function automatic int root_width(int sample_bits, int window_max);
		return (sum_width(sample_bits, window_max) + 2 * FRAC_BITS + 1) / 2;
	endfunction

	function automatic int len_width(int window_max);
		return $clog2(window_max + 1);
	endfunction

	function automatic int ptr_width(int window_max);
		return (window_max > 1) ? $clog2(window_max) : 1;
	endfunction

endpackage

`default_nettype wire

>>> rtl/swre_square.sv
// Bit-serial squarer: one multiplier bit per cycle, shift-add on the upper half.
`default_nettype none

module swre_square import swre_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [SAMPLE_BITS-1:0] operand,
	output logic                          busy,
	output logic [2*SAMPLE_BITS-2:0]      square
);

	localparam int SB    = SAMPLE_BITS;
	localparam int CNT_W = $clog2(SB + 1);

	logic [SB-1:0]    mag;
	logic [SB-1:0]    mcand_q;
	logic [2*SB-1:0]  acc_q;
	logic [SB:0]      part_sum;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	assign mag      = operand[SB-1] ? SB'(-operand) : SB'(operand);
	assign part_sum = {1'b0, acc_q[2*SB-1:SB]} + (acc_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(SB - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mag;
			acc_q   <= {{SB{1'b0}}, mag};
		end else if (busy_q) begin
			acc_q <= {part_sum, acc_q[SB-1:1]};
		end
	end

	assign busy   = busy_q;
	assign square = acc_q[2*SB-2:0];

endmodule

`default_nettype wire

>>> rtl/swre_root.sv
// Digit-by-digit integer square root: two radicand bits in, one root bit out per cycle.
`default_nettype none

module swre_root import swre_pkg::*; #(
	parameter int ROOT_W = 29
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2*ROOT_W-1:0]   radicand,
	output logic                  busy,
	output logic [ROOT_W-1:0]     root
);

	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W+1:0]  cat;
	logic [REM_W+1:0]  trial;
	logic              ge;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;

	assign cat   = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial = (REM_W + 2)'({root_q, 2'b01});
	assign ge    = cat >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(ROOT_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? REM_W'(cat - trial) : REM_W'(cat);
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

`default_nettype wire

>>> rtl/swre_divide.sv
// Restoring divider: one quotient bit per cycle.
`default_nettype none

module swre_divide import swre_pkg::*; #(
	parameter int DIVIDEND_W = 29,
	parameter int DIVISOR_W  = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  busy,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W:0]    cat;
	logic                  ge;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;

	assign cat = {rem_q, quo_q[DIVIDEND_W-1]};
	assign ge  = cat >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIVIDEND_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DIVISOR_W'(cat - {1'b0, den_q}) : DIVISOR_W'(cat);
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> rtl/sliding_window_root_energy.sv
// Sliding-window root energy: delay line memory, window sum, bit-serial square, root, divide.
// Skipped samples only advance the count; window-filling samples pass load, square, sub, add.
// A result word is taken into the output register before the next sample word is accepted;
// squarer, root and divider loops each run one bit per cycle, one after the other.
// Reset clears sum, pointer, count; window to 32 (at most WINDOW_MAX); no delay line clearing pass.
`default_nettype none

module sliding_window_root_energy import swre_pkg::*; #(
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_valid,
	output logic                                          cfg_ready,
	input  logic [CFG_W-1:0]                              window_length,
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0]                 sample,
	output logic                                          out_valid,
	input  logic                                          out_ready,
	output logic [root_width(SAMPLE_BITS, WINDOW_MAX)-1:0] energy
);

	localparam int SB     = SAMPLE_BITS;
	localparam int SUM_W  = sum_width(SAMPLE_BITS, WINDOW_MAX);
	localparam int ROOT_W = root_width(SAMPLE_BITS, WINDOW_MAX);
	localparam int LEN_W  = len_width(WINDOW_MAX);
	localparam int PTR_W  = ptr_width(WINDOW_MAX);
	localparam int SEEN_W = LEN_W + 1;
	localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam logic [LEN_W-1:0] LEN_RESET =
		LEN_W'((WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_LOAD   = 9'b000000010,
		ST_SQUARE = 9'b000000100,
		ST_SUB    = 9'b000001000,
		ST_ADD    = 9'b000010000,
		ST_RSTART = 9'b000100000,
		ST_RWAIT  = 9'b001000000,
		ST_DWAIT  = 9'b010000000,
		ST_OUT    = 9'b100000000
	} state_t;

	state_t                 state_q;
	logic [LEN_W-1:0]       w_q;
	logic [LEN_W-1:0]       w_clamped;
	logic [PTR_W-1:0]       wptr_q;
	logic [LEN_W-1:0]       wptr_inc;
	logic [SEEN_W-1:0]      seen_q;
	logic [SEEN_W-1:0]      two_w;
	logic [SUM_W-1:0]       sum_q;
	logic                   full_q;
	logic                   emit_q;
	logic signed [SB-1:0]   sample_q;
	logic signed [SB-1:0]   rd_q;
	logic [SB-1:0]          mem [WINDOW_MAX];
	logic                   out_valid_q;
	logic [ROOT_W-1:0]      energy_q;

	logic                   in_acc;
	logic                   cfg_acc;
	logic                   out_load;
	logic                   sq_new_busy;
	logic                   sq_old_busy;
	logic                   sq_busy;
	logic [SQ_W-1:0]        sq_new;
	logic [SQ_W-1:0]        sq_old;
	logic                   root_busy;
	logic [ROOT_W-1:0]      root_val;
	logic                   div_start;
	logic                   div_busy;
	logic [ROOT_W-1:0]      quot;

	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign sq_busy   = sq_new_busy || sq_old_busy;
	assign div_start = (state_q == ST_RWAIT) && !root_busy;
	assign two_w     = {w_q, 1'b0};
	assign wptr_inc  = LEN_W'(wptr_q) + LEN_W'(1);

	always_comb begin
		if (window_length == '0) begin
			w_clamped = LEN_W'(1);
		end else if (int'(window_length) > WINDOW_MAX) begin
			w_clamped = LEN_W'(WINDOW_MAX);
		end else begin
			w_clamped = LEN_W'(window_length);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			w_q         <= LEN_RESET;
			wptr_q      <= '0;
			seen_q      <= '0;
			sum_q       <= '0;
			full_q      <= 1'b0;
			emit_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_acc) begin
						w_q    <= w_clamped;
						wptr_q <= '0;
						seen_q <= '0;
						sum_q  <= '0;
					end else if (in_acc) begin
						if (seen_q < SEEN_W'(w_q)) begin
							seen_q <= seen_q + SEEN_W'(1);
						end else begin
							full_q  <= seen_q >= two_w;
							emit_q  <= (seen_q + SEEN_W'(1)) >= two_w;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					state_q <= ST_SQUARE;
				end
				ST_SQUARE: begin
					if (!sq_busy) begin
						state_q <= ST_SUB;
					end
				end
				ST_SUB: begin
					if (full_q) begin
						sum_q <= sum_q - SUM_W'(sq_old);
					end
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					sum_q <= sum_q + SUM_W'(sq_new);
					if (!full_q) begin
						seen_q <= seen_q + SEEN_W'(1);
					end
					wptr_q  <= (wptr_inc >= w_q) ? '0 : PTR_W'(wptr_inc);
					state_q <= emit_q ? ST_RSTART : ST_IDLE;
				end
				ST_RSTART: begin
					state_q <= ST_RWAIT;
				end
				ST_RWAIT: begin
					if (!root_busy) begin
						state_q <= ST_DWAIT;
					end
				end
				ST_DWAIT: begin
					if (!div_busy) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= sample;
		end
		if (out_load) begin
			energy_q <= quot;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_q <= mem[wptr_q];
		end
		if (state_q == ST_LOAD) begin
			mem[wptr_q] <= sample_q;
		end
	end

	swre_square #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_sq_new (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_LOAD),
		.operand(sample_q),
		.busy   (sq_new_busy),
		.square (sq_new)
	);

	swre_square #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_sq_old (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_LOAD),
		.operand(rd_q),
		.busy   (sq_old_busy),
		.square (sq_old)
	);

	swre_root #(
		.ROOT_W(ROOT_W)
	) u_root (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_RSTART),
		.radicand(RAD_W'({sum_q, {(2 * FRAC_BITS){1'b0}}})),
		.busy    (root_busy),
		.root    (root_val)
	);

	swre_divide #(
		.DIVIDEND_W(ROOT_W),
		.DIVISOR_W (LEN_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(root_val),
		.divisor (w_q),
		.busy    (div_busy),
		.quotient(quot)
	);

	assign out_valid = out_valid_q;
	assign energy    = energy_q;

endmodule

`default_nettype wire

>>> rtl/swre_checker.sv
// Port-level checker for the sliding-window root energy block, with its bind.
`default_nettype none

module swre_checker import swre_pkg::*; #(
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input wire logic                                          clk,
	input wire logic                                          arst_n,
	input wire logic                                          cfg_valid,
	input wire logic                                          cfg_ready,
	input wire logic [CFG_W-1:0]                              window_length,
	input wire logic                                          in_valid,
	input wire logic                                          in_ready,
	input wire logic signed [SAMPLE_BITS-1:0]                 sample,
	input wire logic                                          out_valid,
	input wire logic                                          out_ready,
	input wire logic [root_width(SAMPLE_BITS, WINDOW_MAX)-1:0] energy
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(energy))
		else $error("result word changed while stalled");

	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result word appeared while input side was open");

	a_no_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result word one cycle after sample word");

	a_cfg_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !in_ready)
		else $error("sample word taken together with register write");

endmodule

bind sliding_window_root_energy swre_checker #(
	.WINDOW_MAX (WINDOW_MAX),
	.SAMPLE_BITS(SAMPLE_BITS)
) u_swre_checker (.*);

`default_nettype wire

>>> sim/sliding_window_root_energy_tb.sv
// Self-checking testbench for the sliding-window root energy block.
`default_nettype none

module sliding_window_root_energy_tb import swre_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENERGY_W     = root_width(SAMPLE_BITS_DEF, WINDOW_MAX_DEF);
	localparam int DRAIN_CYCLES = 120;
	localparam int CYCLE_LIMIT  = 3000000;
	localparam int RANDOM_WORDS = 360;
	localparam int LONG_WINDOW  = 128;
	localparam int HOLD_AFTER   = 60;
	localparam int HOLD_CYCLES  = 2500;
	localparam int NUM_ROWS     = 21;

	typedef enum bit {ROW_SAMPLE, ROW_WINDOW} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		int          value;
		int          count;
		bit          typed;
		int unsigned expected;
	} plan_row_t;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [CFG_W-1:0]                  window_length;
	logic                              in_valid;
	logic                              in_ready;
	logic signed [SAMPLE_BITS_DEF-1:0] sample;
	logic                              out_valid;
	logic                              out_ready;
	logic [ENERGY_W-1:0]               energy;

	sliding_window_root_energy dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.window_length (window_length),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.energy        (energy)
	);

	logic [ENERGY_W-1:0]        energy_q [$];
	logic [SAMPLE_BITS_DEF-1:0] line_mem [WINDOW_MAX_DEF];
	int unsigned                win_len;
	int unsigned                seen_cnt;
	int unsigned                wr_ptr;
	longint unsigned            sq_sum;

	int  fail_cnt;
	int  words_sent;
	int  windows_set;
	int  energy_checked;
	int  cycle_cnt;
	bit  sender_calm;

	plan_row_t plan [NUM_ROWS];

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d energy words outstanding", $time, energy_q.size());
			$display("FAILURE");
			$finish;
		end
	end

	function automatic longint unsigned square16(input logic signed [SAMPLE_BITS_DEF-1:0] s);
		longint v;
		v = s;
		return v * v;
	endfunction

	function automatic longint unsigned isqrt64(input longint unsigned x);
		longint unsigned rem;
		longint unsigned res;
		longint unsigned b;
		rem = x;
		res = 0;
		b   = 64'h4000_0000_0000_0000;
		while (b > rem)
			b >>= 2;
		while (b != 0) begin
			if (rem >= res + b) begin
				rem -= res + b;
				res  = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic void set_window(input logic [CFG_W-1:0] v);
		if (v == 0)
			win_len = 1;
		else if (v > WINDOW_MAX_DEF)
			win_len = WINDOW_MAX_DEF;
		else
			win_len = v;
		sq_sum   = 0;
		wr_ptr   = 0;
		seen_cnt = 0;
	endfunction

	task automatic step_window(input logic signed [SAMPLE_BITS_DEF-1:0] s, output bit hit,
			output logic [ENERGY_W-1:0] e);
		int unsigned slot;
		hit = 1'b0;
		e   = '0;
		if (seen_cnt < win_len) begin
			seen_cnt++;
		end else begin
			slot = (wr_ptr >= win_len) ? 0 : wr_ptr;
			if (seen_cnt >= 2 * win_len)
				sq_sum -= square16(line_mem[slot]);
			sq_sum += square16(s);
			line_mem[slot] = s;
			wr_ptr = (slot + 1 >= win_len) ? 0 : slot + 1;
			if (seen_cnt < 2 * win_len)
				seen_cnt++;
			if (seen_cnt >= 2 * win_len) begin
				hit = 1'b1;
				e   = ENERGY_W'(isqrt64(sq_sum << 16) / win_len);
			end
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [SAMPLE_BITS_DEF-1:0] pick_sample(input bit loud);
		int r;
		r = $urandom_range(0, 9);
		if (loud && r < 5)
			return (r < 3) ? 16'sh8000 : 16'sh7fff;
		case (r)
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'($urandom_range(0, 15)) - 16'sd8;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_sample(input logic signed [SAMPLE_BITS_DEF-1:0] s, input bit typed,
			input logic [ENERGY_W-1:0] tval);
		int                  gap;
		bit                  hit;
		logic [ENERGY_W-1:0] e;
		gap = sender_calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		step_window(s, hit, e);
		if (hit)
			energy_q.push_back(typed ? tval : e);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
	endtask

	task automatic write_window(input logic [CFG_W-1:0] v);
		in_valid <= 1'b0;
		while (energy_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid     <= 1'b1;
		window_length <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		set_window(v);
		windows_set++;
	endtask

	// receiver: random stalls, one long hold-off once results are flowing
	initial begin
		int  run_left;
		int  taken;
		bit  hold_done;
		out_ready = 1'b0;
		run_left  = 0;
		taken     = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				taken++;
			if (!hold_done && taken == HOLD_AFTER) begin
				hold_done = 1'b1;
				run_left  = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (run_left > 0) begin
				run_left--;
			end else if ($urandom_range(0, 3) != 0) begin
				out_ready <= 1'b1;
				run_left  = $urandom_range(0, 30);
			end else begin
				out_ready <= 1'b0;
				run_left  = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (energy_q.size() == 0) begin
				$display("%0t: unexpected energy word, expected none, actual %0d", $time, energy);
				fail_cnt++;
			end else begin
				if (energy !== energy_q[0]) begin
					$display("%0t: energy mismatch, expected %0d, actual %0d",
						$time, energy_q[0], energy);
					fail_cnt++;
				end
				void'(energy_q.pop_front());
				energy_checked++;
			end
		end
	end

	initial begin
		int                  i;
		int                  j;
		int                  r;
		int                  n;
		int                  rand_words;
		logic [CFG_W-1:0]    v;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		window_length = '0;
		in_valid      = 1'b0;
		sample        = '0;
		fail_cnt      = 0;
		words_sent    = 0;
		windows_set   = 0;
		energy_checked = 0;
		cycle_cnt     = 0;
		sender_calm   = 1'b0;
		rand_words    = 0;
		for (i = 0; i < WINDOW_MAX_DEF; i++)
			line_mem[i] = '0;
		set_window(CFG_W'(WINDOW_RESET));

		plan = '{
			'{ROW_SAMPLE, 1,      64, 1'b1, 45},
			'{ROW_WINDOW, 0,      1,  1'b0, 0},
			'{ROW_SAMPLE, 5,      1,  1'b0, 0},
			'{ROW_SAMPLE, 32767,  1,  1'b1, 8388352},
			'{ROW_SAMPLE, -32768, 1,  1'b1, 8388608},
			'{ROW_SAMPLE, 0,      1,  1'b1, 0},
			'{ROW_SAMPLE, -1,     1,  1'b1, 256},
			'{ROW_SAMPLE, 1,      1,  1'b1, 256},
			'{ROW_WINDOW, 4,      1,  1'b0, 0},
			'{ROW_SAMPLE, -32768, 9,  1'b1, 4194304},
			'{ROW_SAMPLE, 32767,  1,  1'b0, 0},
			'{ROW_SAMPLE, -12345, 1,  1'b0, 0},
			'{ROW_WINDOW, 3,      1,  1'b0, 0},
			'{ROW_SAMPLE, 100,    4,  1'b0, 0},
			'{ROW_SAMPLE, -7,     5,  1'b0, 0},
			'{ROW_WINDOW, 1024,   1,  1'b0, 0},
			'{ROW_SAMPLE, 77,     3,  1'b0, 0},
			'{ROW_WINDOW, 1025,   1,  1'b0, 0},
			'{ROW_SAMPLE, -32768, 3,  1'b0, 0},
			'{ROW_WINDOW, 2,      1,  1'b0, 0},
			'{ROW_SAMPLE, 32767,  6,  1'b0, 0}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < NUM_ROWS; i++) begin
			if (plan[i].kind == ROW_WINDOW)
				write_window(CFG_W'(plan[i].value));
			else
				for (j = 0; j < plan[i].count; j++)
					send_sample(16'(plan[i].value), plan[i].typed, ENERGY_W'(plan[i].expected));
		end

		while (rand_words < RANDOM_WORDS) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				v = CFG_W'($urandom_range(1, 16));
			else if (r < 85)
				v = CFG_W'($urandom_range(17, 64));
			else
				v = CFG_W'($urandom_range(0, 2047));
			n = (r < 85) ? 2 * int'(v) + $urandom_range(4, 30) : $urandom_range(1, 12);
			sender_calm = ($urandom_range(0, 3) == 0);
			write_window(v);
			repeat (n) send_sample(pick_sample(1'b0), 1'b0, '0);
			rand_words += n;
		end

		// long window, loud samples to drive the sum and root toward their extremes
		sender_calm = 1'b0;
		write_window(CFG_W'(LONG_WINDOW));
		repeat (2 * LONG_WINDOW + 12) send_sample(pick_sample(1'b1), 1'b0, '0);

		in_valid <= 1'b0;
		while (energy_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d sample words over %0d window settings,", words_sent,
			windows_set + 1);
		$display("with %0d energy words checked and %0d mismatches.", energy_checked, fail_cnt);
		if (fail_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
